>>> hdl/multitouch_event_encoder_defines.svh
// Assertion macros used by the encoder sequencer.
`ifndef MULTITOUCH_EVENT_ENCODER_DEFINES_SVH
`define MULTITOUCH_EVENT_ENCODER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MTE_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("assertion failed");
// Implication whose consequent is checked in the cycle after its antecedent.
`define MTE_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

>>> hdl/mte_pkg.sv
// Types, codes and constants of the multitouch event encoder.
package mte_pkg;
	localparam int MaxContactsDefault = 8;
	localparam logic [2:0] KIND_COMMIT = 3'd0;
	localparam logic [2:0] KIND_RESET  = 3'd1;
	localparam logic [2:0] KIND_DOWN   = 3'd2;
	localparam logic [2:0] KIND_MOVE   = 3'd3;
	localparam logic [2:0] KIND_UP     = 3'd4;
	localparam logic [1:0] CL_ABS = 2'd0;
	localparam logic [1:0] CL_KEY = 2'd1;
	localparam logic [1:0] CL_SYN = 2'd2;
	localparam logic [3:0] EV_SLOT  = 4'd0;
	localparam logic [3:0] EV_TRACK = 4'd1;
	localparam logic [3:0] EV_TMAJ  = 4'd2;
	localparam logic [3:0] EV_WMAJ  = 4'd3;
	localparam logic [3:0] EV_PRESS = 4'd4;
	localparam logic [3:0] EV_X     = 4'd5;
	localparam logic [3:0] EV_Y     = 4'd6;
	localparam logic [3:0] EV_BTN   = 4'd7;
	localparam logic [3:0] EV_CREP  = 4'd8;
	localparam logic [3:0] EV_FREP  = 4'd9;
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DOWN = 2'd1;
	localparam logic [1:0] PH_MOVE = 2'd2;
	localparam logic [1:0] PH_UP   = 2'd3;
	localparam logic [2:0] REG_SLOT_MODE = 3'd0;
	localparam logic [2:0] REG_EMIT_TRK  = 3'd1;
	localparam logic [2:0] REG_EMIT_BTN  = 3'd2;
	localparam logic [2:0] REG_EMIT_TMAJ = 3'd3;
	localparam logic [2:0] REG_EMIT_WMAJ = 3'd4;
	localparam logic [2:0] REG_EMIT_PRS  = 3'd5;
	localparam logic [2:0] REG_LIMIT     = 3'd6;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  contact;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] press;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         event_class;
		logic [3:0]         event_code;
		logic signed [31:0] event_value;
		logic               last;
	} evt_t;

	typedef struct packed {
		logic       slot_mode;
		logic       emit_tracking;
		logic       emit_button;
		logic       emit_touch_major;
		logic       emit_width_major;
		logic       emit_pressure;
		logic [3:0] contact_limit;
	} cfg_t;

	// States of the sequencer, including its event emission steps.
	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_BRESET, ST_ARESET, ST_WALK, ST_REPORT,
		ST_E_SLOT, ST_E_TRACK, ST_E_BTN, ST_E_TMAJ, ST_E_WMAJ, ST_E_PRESS,
		ST_E_X, ST_E_Y, ST_E_CREP, ST_E_FREP, ST_AFTER
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic       load;
		logic       emit;
		logic [1:0] ev_class;
		logic [3:0] ev_code;
		logic [3:0] val_sel;
		logic       from_store;
		logic       last;
		logic       set_phase;
		logic       phase_from_cmd;
		logic [1:0] phase_val;
		logic       store_pos;
		logic       cnt_up;
		logic       cnt_down;
		logic       trk_inc;
		logic       walk_clear;
		logic       walk_next;
		logic       breset_all;
		logic       areset_mark;
		logic       any_set;
		logic       any_clr;
	} ctl_t;

	// Datapath to controller.
	typedef struct packed {
		logic       ok;
		logic [1:0] cmd_phase;
		logic [1:0] walk_phase;
		logic       walk_done;
		logic       any_busy;
		logic       any_q;
		logic       cnt_is0_next_down;
		logic       cnt_is0;
		logic       cnt_is1;
	} sts_t;

	localparam logic [3:0] VAL_ZERO  = 4'd0;
	localparam logic [3:0] VAL_CONT  = 4'd1;
	localparam logic [3:0] VAL_TRK   = 4'd2;
	localparam logic [3:0] VAL_MINUS = 4'd3;
	localparam logic [3:0] VAL_ONE   = 4'd4;
	localparam logic [3:0] VAL_SIX   = 4'd5;
	localparam logic [3:0] VAL_FOUR  = 4'd6;
	localparam logic [3:0] VAL_PRESS = 4'd7;
	localparam logic [3:0] VAL_X     = 4'd8;
	localparam logic [3:0] VAL_Y     = 4'd9;
endpackage

>>> hdl/mte_datapath.sv
// Contact store, counters and event output register of the encoder.
module mte_datapath #(
	parameter int NUM_CONTACTS = mte_pkg::MaxContactsDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mte_pkg::cmd_t  cmd,
	input  mte_pkg::cfg_t  cfg,
	input  mte_pkg::ctl_t  ctl,
	output mte_pkg::sts_t  sts,
	output logic           strobe,
	output mte_pkg::evt_t  result
);
	import mte_pkg::*;
	localparam int CW = (NUM_CONTACTS > 1) ? $clog2(NUM_CONTACTS) : 1;

	cmd_t            cmd_q;
	logic [1:0]      phase_q [NUM_CONTACTS];
	logic [15:0]     x_q     [NUM_CONTACTS];
	logic [15:0]     y_q     [NUM_CONTACTS];
	logic [15:0]     p_q     [NUM_CONTACTS];
	logic signed [7:0] cnt_q;
	logic [30:0]     trk_q;
	logic [3:0]      walk_q;
	logic            any_q;
	logic [3:0]      lim;
	logic [CW-1:0]   cidx;
	logic [CW-1:0]   widx;
	logic signed [31:0] val;

	assign lim  = (cfg.contact_limit < 4'(NUM_CONTACTS)) ? cfg.contact_limit
		: 4'(NUM_CONTACTS);
	assign cidx = cmd_q.contact[CW-1:0];
	assign widx = walk_q[CW-1:0];

	always_comb begin
		sts.ok         = {1'b0, cmd_q.contact} < {5'd0, lim};
		sts.cmd_phase  = sts.ok ? phase_q[cidx] : PH_IDLE;
		sts.walk_done  = walk_q >= lim;
		sts.walk_phase = sts.walk_done ? PH_IDLE : phase_q[widx];
		sts.any_busy   = 1'b0;
		for (int i = 0; i < NUM_CONTACTS; i++)
			if (4'(i) < lim && phase_q[i] != PH_IDLE) sts.any_busy = 1'b1;
		sts.any_q = any_q;
		sts.cnt_is0_next_down = (cnt_q == 8'sd1);
		sts.cnt_is0 = (cnt_q == 8'sd0);
		sts.cnt_is1 = (cnt_q == 8'sd1);
	end

	// During a type A walk the values come from the walked contact's entry.
	always_comb begin
		unique case (ctl.val_sel)
			VAL_ZERO:  val = '0;
			VAL_CONT:  val = ctl.from_store ? 32'(walk_q) : 32'(cmd_q.contact);
			VAL_TRK:   val = {1'b0, trk_q};
			VAL_MINUS: val = -32'sd1;
			VAL_ONE:   val = 32'sd1;
			VAL_SIX:   val = 32'sd6;
			VAL_FOUR:  val = 32'sd4;
			VAL_PRESS: val = 32'(ctl.from_store ? p_q[widx] : cmd_q.press);
			VAL_X:     val = 32'(ctl.from_store ? x_q[widx] : cmd_q.pos_x);
			VAL_Y:     val = 32'(ctl.from_store ? y_q[widx] : cmd_q.pos_y);
			default:   val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CONTACTS; i++) phase_q[i] <= PH_IDLE;
			cnt_q  <= '0;
			trk_q  <= '0;
			walk_q <= '0;
			any_q  <= 1'b0;
			strobe <= 1'b0;
		end else begin
			strobe <= ctl.emit;
			if (ctl.set_phase) begin
				if (ctl.phase_from_cmd) phase_q[cidx] <= ctl.phase_val;
				else phase_q[widx] <= ctl.phase_val;
			end
			if (ctl.breset_all || ctl.areset_mark) begin
				for (int i = 0; i < NUM_CONTACTS; i++) begin
					if (4'(i) < lim) begin
						if (ctl.breset_all) phase_q[i] <= PH_IDLE;
						else if (phase_q[i] == PH_DOWN || phase_q[i] == PH_MOVE)
							phase_q[i] <= PH_UP;
					end
				end
			end
			if (ctl.cnt_up && cnt_q != 8'sd127) cnt_q <= cnt_q + 8'sd1;
			if (ctl.cnt_down && cnt_q != -8'sd127) cnt_q <= cnt_q - 8'sd1;
			if (ctl.trk_inc) trk_q <= (trk_q == '1) ? '0 : trk_q + 31'd1;
			if (ctl.walk_clear) walk_q <= '0;
			else if (ctl.walk_next) walk_q <= walk_q + 4'd1;
			if (ctl.any_clr) any_q <= 1'b0;
			else if (ctl.any_set) any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) cmd_q <= cmd;
		if (ctl.store_pos) begin
			x_q[cidx] <= cmd_q.pos_x;
			y_q[cidx] <= cmd_q.pos_y;
			p_q[cidx] <= cmd_q.press;
		end
		if (ctl.emit) begin
			result.event_class <= ctl.ev_class;
			result.event_code  <= ctl.ev_code;
			result.event_value <= val;
			result.last        <= ctl.last;
		end
	end
endmodule

>>> hdl/mte_control.sv
// Sequencer that decodes a command and steps through its events.
module mte_control (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mte_pkg::cmd_t cmd,
	input  mte_pkg::cfg_t cfg,
	input  mte_pkg::sts_t sts,
	output logic          busy,
	output mte_pkg::ctl_t ctl
);
	import mte_pkg::*;
	`include "multitouch_event_encoder_defines.svh"

	state_t st_q, st_d;
	logic [2:0] kind_q;
	logic       walk_mode_q, walk_mode_d;   // 1 while a type A walk runs
	logic       after_down_q, after_down_d; // a down follows the reset pass
	logic       up_q, up_d;                 // walked contact is going up
	logic       dn_q, dn_d;                 // walked contact went down
	logic       btn_q;                      // button event due in this report
	logic       btn_d;

	// Picks the next enabled shape event after the given step, else the X event.
	function automatic state_t next_shape(input cfg_t c, input state_t from);
		state_t r;
		r = ST_E_X;
		if (from == ST_E_TRACK || from == ST_E_BTN) begin
			if (c.emit_touch_major) r = ST_E_TMAJ;
			else if (c.emit_width_major) r = ST_E_WMAJ;
			else if (c.emit_pressure) r = ST_E_PRESS;
		end else if (from == ST_E_TMAJ) begin
			if (c.emit_width_major) r = ST_E_WMAJ;
			else if (c.emit_pressure) r = ST_E_PRESS;
		end else if (from == ST_E_WMAJ) begin
			if (c.emit_pressure) r = ST_E_PRESS;
		end
		return r;
	endfunction

	assign busy = st_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			kind_q <= KIND_COMMIT;
			walk_mode_q <= 1'b0;
			after_down_q <= 1'b0;
			up_q <= 1'b0;
			dn_q <= 1'b0;
			btn_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (start && !busy) kind_q <= cmd.kind;
			walk_mode_q <= walk_mode_d;
			after_down_q <= after_down_d;
			up_q <= up_d;
			dn_q <= dn_d;
			btn_q <= btn_d;
		end
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		walk_mode_d = walk_mode_q;
		after_down_d = after_down_q;
		up_d = up_q;
		dn_d = dn_q;
		btn_d = btn_q;
		unique case (st_q)
			ST_IDLE: if (start) st_d = ST_DECODE;
			ST_DECODE: begin
				after_down_d = 1'b0;
				walk_mode_d = 1'b0;
				case (kind_q) inside
					KIND_COMMIT: begin
						if (cfg.slot_mode) st_d = ST_E_FREP;
						else begin
							st_d = ST_WALK;
							walk_mode_d = 1'b1;
						end
					end
					KIND_RESET: st_d = cfg.slot_mode ? ST_BRESET : ST_ARESET;
					KIND_DOWN: begin
						if (!sts.ok) st_d = ST_IDLE;
						else if (sts.cmd_phase != PH_IDLE) begin
							after_down_d = 1'b1;
							st_d = cfg.slot_mode ? ST_BRESET : ST_ARESET;
						end else st_d = ST_AFTER;
					end
					KIND_MOVE, KIND_UP: begin
						if (!sts.ok || sts.cmd_phase == PH_IDLE) st_d = ST_IDLE;
						else st_d = cfg.slot_mode ? ST_E_SLOT : ST_AFTER;
					end
					default: st_d = ST_IDLE;
				endcase
			end
			ST_BRESET: st_d = sts.any_busy ? ST_E_FREP : ST_AFTER;
			ST_ARESET: begin
				st_d = ST_WALK;
				walk_mode_d = 1'b1;
			end
			ST_WALK: begin
				if (sts.walk_done) st_d = sts.any_q ? ST_E_FREP : ST_AFTER;
				else if (sts.walk_phase != PH_IDLE) begin
					st_d = ST_REPORT;
					up_d = sts.walk_phase == PH_UP;
					dn_d = sts.walk_phase == PH_DOWN;
				end
			end
			ST_REPORT: begin
				// The count has settled; decide on the button here.
				btn_d = cfg.emit_button && (up_q ? sts.cnt_is0 : (dn_q && sts.cnt_is1));
				if (cfg.emit_tracking) st_d = ST_E_TRACK;
				else if (btn_d) st_d = ST_E_BTN;
				else st_d = up_q ? ST_E_CREP : next_shape(cfg, ST_E_BTN);
			end
			ST_E_SLOT: begin
				if (kind_q == KIND_MOVE) st_d = next_shape(cfg, ST_E_TRACK);
				else st_d = ST_E_TRACK;
			end
			ST_E_TRACK: begin
				if (walk_mode_q) st_d = btn_q ? ST_E_BTN
					: (up_q ? ST_E_CREP : next_shape(cfg, ST_E_TRACK));
				else if (btn_q) st_d = ST_E_BTN;
				else st_d = (kind_q == KIND_UP) ? ST_IDLE : next_shape(cfg, ST_E_TRACK);
			end
			ST_E_BTN: begin
				if (walk_mode_q) st_d = up_q ? ST_E_CREP : next_shape(cfg, ST_E_BTN);
				else st_d = (kind_q == KIND_UP) ? ST_IDLE : next_shape(cfg, ST_E_BTN);
			end
			ST_E_TMAJ: st_d = next_shape(cfg, ST_E_TMAJ);
			ST_E_WMAJ: st_d = next_shape(cfg, ST_E_WMAJ);
			ST_E_PRESS: st_d = ST_E_X;
			ST_E_X: st_d = ST_E_Y;
			ST_E_Y: st_d = walk_mode_q ? ST_E_CREP : ST_IDLE;
			ST_E_CREP: st_d = ST_WALK;
			ST_E_FREP: st_d = (kind_q == KIND_DOWN && after_down_q) ? ST_AFTER : ST_IDLE;
			ST_AFTER: st_d = (kind_q == KIND_DOWN && cfg.slot_mode) ? ST_E_SLOT : ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
		// A slot mode down has counted already; an up counts at this very edge.
		if (st_q == ST_E_SLOT && kind_q == KIND_DOWN)
			btn_d = cfg.emit_button && sts.cnt_is1;
		if (st_q == ST_E_SLOT && kind_q == KIND_UP)
			btn_d = cfg.emit_button && sts.cnt_is0_next_down;
	end

	// Outputs.
	always_comb begin
		logic more;
		ctl = '0;
		ctl.from_store = walk_mode_q;
		more = 1'b1;
		unique case (st_q)
			ST_IDLE: ctl.load = start;
			ST_DECODE: begin
				ctl.walk_clear = 1'b1;
				ctl.any_clr = 1'b1;
			end
			ST_BRESET: ctl.breset_all = 1'b1;
			ST_ARESET: ctl.areset_mark = 1'b1;
			ST_WALK: begin
				if (!sts.walk_done && sts.walk_phase != PH_IDLE) begin
					ctl.any_set = 1'b1;
					ctl.cnt_up = sts.walk_phase == PH_DOWN;
					ctl.cnt_down = sts.walk_phase == PH_UP;
				end else if (!sts.walk_done) ctl.walk_next = 1'b1;
			end
			ST_REPORT: ;
			ST_E_SLOT: begin
				ctl.emit = 1'b1;
				ctl.ev_class = CL_ABS;
				ctl.ev_code = EV_SLOT;
				ctl.val_sel = VAL_CONT;
				ctl.last = 1'b0;
			end
			ST_E_TRACK: begin
				ctl.emit = 1'b1;
				ctl.ev_class = CL_ABS;
				ctl.ev_code = EV_TRACK;
				if (walk_mode_q) ctl.val_sel = VAL_CONT;
				else ctl.val_sel = (kind_q == KIND_UP) ? VAL_MINUS : VAL_TRK;
				ctl.last = !walk_mode_q && kind_q == KIND_UP && !btn_q;
			end
			ST_E_BTN: begin
				ctl.emit = 1'b1;
				ctl.ev_class = CL_KEY;
				ctl.ev_code = EV_BTN;
				ctl.val_sel = (up_q && walk_mode_q) || (!walk_mode_q && kind_q == KIND_UP)
					? VAL_ZERO : VAL_ONE;
				ctl.last = !walk_mode_q && kind_q == KIND_UP;
			end
			ST_E_TMAJ: begin
				ctl.emit = 1'b1;
				ctl.ev_class = CL_ABS;
				ctl.ev_code = EV_TMAJ;
				ctl.val_sel = VAL_SIX;
			end
			ST_E_WMAJ: begin
				ctl.emit = 1'b1;
				ctl.ev_class = CL_ABS;
				ctl.ev_code = EV_WMAJ;
				ctl.val_sel = VAL_FOUR;
			end
			ST_E_PRESS: begin
				ctl.emit = 1'b1;
				ctl.ev_class = CL_ABS;
				ctl.ev_code = EV_PRESS;
				ctl.val_sel = VAL_PRESS;
			end
			ST_E_X: begin
				ctl.emit = 1'b1;
				ctl.ev_class = CL_ABS;
				ctl.ev_code = EV_X;
				ctl.val_sel = VAL_X;
			end
			ST_E_Y: begin
				ctl.emit = 1'b1;
				ctl.ev_class = CL_ABS;
				ctl.ev_code = EV_Y;
				ctl.val_sel = VAL_Y;
				ctl.last = !walk_mode_q;
			end
			ST_E_CREP: begin
				ctl.emit = 1'b1;
				ctl.ev_class = CL_SYN;
				ctl.ev_code = EV_CREP;
				ctl.val_sel = VAL_ZERO;
				ctl.set_phase = 1'b1;
				ctl.phase_val = up_q ? PH_IDLE : PH_MOVE;
				ctl.walk_next = 1'b1;
			end
			ST_E_FREP: begin
				ctl.emit = 1'b1;
				ctl.ev_class = CL_SYN;
				ctl.ev_code = EV_FREP;
				ctl.val_sel = VAL_ZERO;
				ctl.last = !(kind_q == KIND_DOWN && after_down_q && cfg.slot_mode);
			end
			ST_AFTER: begin
				if (kind_q == KIND_DOWN) begin
					ctl.set_phase = 1'b1;
					ctl.phase_from_cmd = 1'b1;
					ctl.phase_val = PH_DOWN;
					ctl.store_pos = !cfg.slot_mode;
					ctl.cnt_up = cfg.slot_mode;
					ctl.trk_inc = cfg.slot_mode;
				end else if (kind_q == KIND_MOVE) begin
					// Type A move and up only record the contact.
					ctl.set_phase = 1'b1;
					ctl.phase_from_cmd = 1'b1;
					ctl.phase_val = PH_MOVE;
					ctl.store_pos = 1'b1;
				end else if (kind_q == KIND_UP) begin
					ctl.set_phase = 1'b1;
					ctl.phase_from_cmd = 1'b1;
					ctl.phase_val = PH_UP;
				end
			end
			default: more = 1'b0;
		endcase
		// Slot mode up acts on entering the slot event.
		if (st_q == ST_E_SLOT && kind_q == KIND_UP) begin
			ctl.set_phase = 1'b1;
			ctl.phase_from_cmd = 1'b1;
			ctl.phase_val = PH_IDLE;
			ctl.cnt_down = 1'b1;
		end
		if (!more) ctl = '0;
	end

	`MTE_ASSERT_IMP(a_emit_busy, ctl.emit, busy)
	`MTE_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`MTE_ASSERT_IMP(a_cnt_excl, ctl.cnt_up, !ctl.cnt_down)
endmodule

>>> hdl/multitouch_event_encoder.sv
// Top level of the multitouch event encoder.
// Usage: raise start with a command on cmd while busy is low; the command is
// taken at that edge and busy is high from the next cycle until the command
// is done. Each event is shown on result for one cycle with strobe high and
// is registered in the cycle after the sequencer step that makes it, so the
// last event of a command comes in the first cycle after busy falls, except
// for a type A down on a busy contact, whose last event comes while busy is
// still high; result.last marks it. A command that causes no event simply
// drops busy. One command runs at a time; the next one may be taken in the
// cycle in which busy falls. In slot mode the longest command is a down on a
// busy slot with every optional event. A type A commit visits each contact in
// turn and reports each one that is not idle.
// The user must write configuration through cfg_we, cfg_index and cfg_data
// only while the block is idle; the block itself does not enforce this. Reset
// clears all contacts to idle, the active count and the tracking number, and
// loads the register defaults. The receiver cannot stall: every strobe must
// be taken in its cycle.
module multitouch_event_encoder #(
	parameter int NUM_CONTACTS = mte_pkg::MaxContactsDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mte_pkg::cmd_t cmd,
	output logic          strobe,
	output mte_pkg::evt_t result,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [3:0]    cfg_data
);
	import mte_pkg::*;

	cfg_t cfg_q;
	ctl_t ctl;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{slot_mode: 1'b1, emit_tracking: 1'b1, emit_button: 1'b1,
				emit_touch_major: 1'b0, emit_width_major: 1'b0, emit_pressure: 1'b0,
				contact_limit: 4'd8};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOT_MODE: cfg_q.slot_mode <= cfg_data[0];
				REG_EMIT_TRK:  cfg_q.emit_tracking <= cfg_data[0];
				REG_EMIT_BTN:  cfg_q.emit_button <= cfg_data[0];
				REG_EMIT_TMAJ: cfg_q.emit_touch_major <= cfg_data[0];
				REG_EMIT_WMAJ: cfg_q.emit_width_major <= cfg_data[0];
				REG_EMIT_PRS:  cfg_q.emit_pressure <= cfg_data[0];
				REG_LIMIT:     cfg_q.contact_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	mte_control u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .cfg(cfg_q),
		.sts(sts), .busy(busy), .ctl(ctl)
	);

	mte_datapath #(.NUM_CONTACTS(NUM_CONTACTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg(cfg_q), .ctl(ctl),
		.sts(sts), .strobe(strobe), .result(result)
	);
endmodule
